FILE: rtl/core/goa3_pkg.sv
// ----------------------------------------------------------------------------
// goa3_pkg: shared types and constants for the glyph outline alpha filter
// Holds field widths, config register indexes, the front-to-back command
// and the size clamps; the front uses both, the back only the width clamp.
// ----------------------------------------------------------------------------
package goa3_pkg;

    localparam int PIX_W       = 8;
    localparam int COL_W       = 6;
    localparam int ROW_W       = 8;
    localparam int GAIN_W      = 8;
    localparam int MAX_WIDTH   = 63;
    localparam int MIN_SIZE    = 3;
    localparam int LINE_DEPTH  = 2 ** COL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 64;

    localparam int DIAG_WEIGHT = 181;
    localparam int SIDE_SHIFT  = 8;
    localparam int GAIN_SHIFT  = 16;
    localparam int SUM_W       = 19;
    localparam int PROD_W      = SUM_W + GAIN_W;

    // config register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTLINE_GAIN = 2'd2;

    localparam logic [COL_W-1:0]  RST_IMAGE_WIDTH  = 6'd16;
    localparam logic [ROW_W-1:0]  RST_IMAGE_HEIGHT = 8'd16;
    localparam logic [GAIN_W-1:0] RST_OUTLINE_GAIN = 8'd128;

    // one classified pixel, front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             pre_emit;   // first column, row >= 2: finish previous row
        logic             clear_win;  // first column: window starts empty
        logic             top_ok;     // row >= 2
        logic             mid_ok;     // row >= 1
        logic             post_emit;  // row >= 1 and column >= 1
        logic             flush;      // final pixel of the image
    } cmd_t;

    function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] w);
        logic [COL_W-1:0] r;
        r = w;
        if (w < COL_W'(MIN_SIZE)) begin
            r = COL_W'(MIN_SIZE);
        end else if (w > COL_W'(MAX_WIDTH)) begin
            r = COL_W'(MAX_WIDTH);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] eff_height(input logic [ROW_W-1:0] h);
        logic [ROW_W-1:0] r;
        r = h;
        if (h < ROW_W'(MIN_SIZE)) begin
            r = ROW_W'(MIN_SIZE);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/goa3_front.sv
// ----------------------------------------------------------------------------
// goa3_front: pixel intake and classification
// Tracks the raster position of the next pixel and turns every accepted
// pixel into a command that tells the back which results it causes.
// ----------------------------------------------------------------------------
module goa3_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [goa3_pkg::COL_W-1:0]    image_width,
    input  logic [goa3_pkg::ROW_W-1:0]    image_height,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [goa3_pkg::PIX_W-1:0]    s_tdata,    // [7:0] pixel_value
    input  logic                          q_full,
    output logic                          q_push,
    output goa3_pkg::cmd_t                q_cmd
);

    logic [goa3_pkg::COL_W-1:0] col_reg, col_next;
    logic [goa3_pkg::ROW_W-1:0] row_reg, row_next;
    logic [goa3_pkg::COL_W-1:0] w_eff, c;
    logic [goa3_pkg::ROW_W-1:0] h_eff, r;
    logic                       oob, is_last;
    logic [goa3_pkg::COL_W:0]   c_inc;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        w_eff   = goa3_pkg::eff_width(image_width);
        h_eff   = goa3_pkg::eff_height(image_height);
        // a size change can leave the position outside the image
        oob     = (col_reg >= w_eff) || (row_reg >= h_eff);
        c       = oob ? '0 : col_reg;
        r       = oob ? '0 : row_reg;
        c_inc   = {1'b0, c} + 1'b1;
        is_last = (r == h_eff - 1'b1) && (c == w_eff - 1'b1);

        q_cmd.pixel     = s_tdata;
        q_cmd.col       = c;
        q_cmd.pre_emit  = (c == '0) && (r >= goa3_pkg::ROW_W'(2));
        q_cmd.clear_win = (c == '0);
        q_cmd.top_ok    = (r >= goa3_pkg::ROW_W'(2));
        q_cmd.mid_ok    = (r != '0);
        q_cmd.post_emit = (r != '0) && (c != '0);
        q_cmd.flush     = is_last;

        col_next = col_reg;
        row_next = row_reg;
        if (q_push) begin
            if (is_last) begin
                col_next = '0;
                row_next = '0;
            end else if (c_inc >= {1'b0, w_eff}) begin
                col_next = '0;
                row_next = r + 1'b1;
            end else begin
                col_next = c_inc[goa3_pkg::COL_W-1:0];
                row_next = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: rtl/core/goa3_fifo.sv
// ----------------------------------------------------------------------------
// goa3_fifo: short command queue between front and back
// Lets the front keep taking pixels while the back works off results.
// ----------------------------------------------------------------------------
module goa3_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  goa3_pkg::cmd_t push_cmd,
    input  logic           pop,
    output goa3_pkg::cmd_t head_cmd,
    output logic           full,
    output logic           empty
);

    goa3_pkg::cmd_t                 mem_reg [goa3_pkg::QUEUE_DEPTH];
    logic [goa3_pkg::QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [goa3_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign full     = (cnt_reg == goa3_pkg::QCNT_W'(goa3_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/goa3_back.sv
// ----------------------------------------------------------------------------
// goa3_back: line stores, 3x3 window and result sequencer
// Pops one command at a time, updates the two line stores and the window,
// and emits results through a registered output stage. The final pixel of
// an image starts a flush pass that replays both stored lines.
// ----------------------------------------------------------------------------
module goa3_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [goa3_pkg::COL_W-1:0]    image_width,
    input  logic [goa3_pkg::GAIN_W-1:0]   outline_gain,
    input  goa3_pkg::cmd_t                q_head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*goa3_pkg::PIX_W-1:0]  m_tdata,    // [7:0] luminance, [15:8] alpha
    output logic                          m_tlast,    // run_last
    output logic                          m_tuser     // image_end
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_PRE  = 10'b00_0000_0010,
        S_MAIN = 10'b00_0000_0100,
        S_FL0  = 10'b00_0000_1000,
        S_FLA  = 10'b00_0001_0000,
        S_FLB  = 10'b00_0010_0000,
        S_FLC  = 10'b00_0100_0000,
        S_FLD  = 10'b00_1000_0000,
        S_SUM  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    typedef logic [8:0][goa3_pkg::PIX_W-1:0] win_t;

    localparam int PW = goa3_pkg::PIX_W;
    localparam int ACC_W = PW + 2;

    logic [PW-1:0] older_mem [goa3_pkg::LINE_DEPTH];
    logic [PW-1:0] newer_mem [goa3_pkg::LINE_DEPTH];

    state_t                          state_reg, state_next;
    state_t                          ret_reg, ret_next;
    goa3_pkg::cmd_t                  cmd_reg;
    logic                            last_reg, last_next;
    logic                            end_reg, end_next;
    logic [goa3_pkg::COL_W-1:0]      x_reg, x_next;
    logic [PW-1:0]                   rd_old_reg, rd_new_reg;
    win_t                            win_reg, win_next;
    logic [goa3_pkg::SUM_W-1:0]      sum_reg;
    logic [PW-1:0]                   lum_reg;
    logic                            m_tvalid_reg;
    logic [2*PW-1:0]                 m_tdata_reg;
    logic                            m_tlast_reg, m_tuser_reg;

    logic                            rd_en, wr_en;
    logic [goa3_pkg::COL_W-1:0]      rd_addr;
    logic [goa3_pkg::COL_W-1:0]      w_eff;
    logic [goa3_pkg::COL_W:0]        x_inc;
    logic                            tail_cut;
    logic [ACC_W-1:0]                side, diag;
    logic [goa3_pkg::SUM_W-1:0]      sum_now;
    logic [goa3_pkg::PROD_W-1:0]     prod;
    logic [goa3_pkg::PROD_W-goa3_pkg::GAIN_SHIFT:0] alpha_wide;
    logic [PW-1:0]                   alpha;
    logic                            out_free, load_out;

    function automatic win_t shift_in(input win_t w, input logic [PW-1:0] t,
                                      input logic [PW-1:0] m, input logic [PW-1:0] b);
        win_t r;
        r    = w;
        r[0] = w[1];
        r[1] = w[2];
        r[2] = t;
        r[3] = w[4];
        r[4] = w[5];
        r[5] = m;
        r[6] = w[7];
        r[7] = w[8];
        r[8] = b;
        return r;
    endfunction

    assign w_eff    = goa3_pkg::eff_width(image_width);
    assign x_inc    = {1'b0, x_reg} + 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == S_OUT) && out_free;
    // final pixel causes width+2 results; past the per-beat cap the closing one is lost
    assign tail_cut = ({1'b0, w_eff} >
                       (goa3_pkg::COL_W+1)'(goa3_pkg::MAX_RESULTS - 2));

    // neighborhood sum, center excluded
    always_comb begin
        side    = ACC_W'(win_reg[1]) + ACC_W'(win_reg[3])
                + ACC_W'(win_reg[5]) + ACC_W'(win_reg[7]);
        diag    = ACC_W'(win_reg[0]) + ACC_W'(win_reg[2])
                + ACC_W'(win_reg[6]) + ACC_W'(win_reg[8]);
        sum_now = (goa3_pkg::SUM_W'(side) << goa3_pkg::SIDE_SHIFT)
                + goa3_pkg::SUM_W'(diag) * goa3_pkg::SUM_W'(goa3_pkg::DIAG_WEIGHT);
    end

    always_comb begin
        prod       = goa3_pkg::PROD_W'(outline_gain) * goa3_pkg::PROD_W'(sum_reg);
        alpha_wide = {1'b0, prod[goa3_pkg::PROD_W-1:goa3_pkg::GAIN_SHIFT]}
                   + ($bits(alpha_wide))'(lum_reg);
        alpha      = (alpha_wide > ($bits(alpha_wide))'(255)) ? 8'hFF
                   : alpha_wide[PW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        x_next     = x_reg;
        win_next   = win_reg;
        rd_en      = 1'b0;
        rd_addr    = q_head.col;
        wr_en      = 1'b0;
        q_pop      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (cmd_reg.pre_emit) begin
                    // close out the previous row with zeros on the right
                    win_next   = shift_in(win_reg, '0, '0, '0);
                    last_next  = !cmd_reg.post_emit && !cmd_reg.flush;
                    end_next   = 1'b0;
                    ret_next   = S_MAIN;
                    state_next = S_SUM;
                end else begin
                    state_next = S_MAIN;
                end
            end
            S_MAIN: begin
                wr_en    = 1'b1;
                win_next = shift_in(cmd_reg.clear_win ? win_t'('0) : win_reg,
                                    cmd_reg.top_ok ? rd_old_reg : '0,
                                    cmd_reg.mid_ok ? rd_new_reg : '0,
                                    cmd_reg.pixel);
                if (cmd_reg.post_emit) begin
                    last_next  = !cmd_reg.flush;
                    end_next   = 1'b0;
                    ret_next   = cmd_reg.flush ? S_FL0 : S_IDLE;
                    state_next = S_SUM;
                end else if (cmd_reg.flush) begin
                    state_next = S_FL0;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FL0: begin
                win_next   = shift_in(win_reg, '0, '0, '0);
                last_next  = 1'b0;
                end_next   = 1'b0;
                ret_next   = S_FLA;
                state_next = S_SUM;
            end
            S_FLA: begin
                win_next   = '0;
                x_next     = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_FLB;
            end
            S_FLB: begin
                // last row: nothing below it
                win_next = shift_in(win_reg, rd_old_reg, rd_new_reg, '0);
                if (x_reg != '0) begin
                    last_next  = tail_cut && (x_inc == {1'b0, w_eff});
                    end_next   = 1'b0;
                    ret_next   = S_FLC;
                    state_next = S_SUM;
                end else begin
                    state_next = S_FLC;
                end
            end
            S_FLC: begin
                if (x_inc < {1'b0, w_eff}) begin
                    x_next     = x_inc[goa3_pkg::COL_W-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = x_inc[goa3_pkg::COL_W-1:0];
                    state_next = S_FLB;
                end else begin
                    state_next = tail_cut ? S_IDLE : S_FLD;
                end
            end
            S_FLD: begin
                win_next   = shift_in(win_reg, '0, '0, '0);
                last_next  = 1'b1;
                end_next   = 1'b1;
                ret_next   = S_IDLE;
                state_next = S_SUM;
            end
            S_SUM: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // line stores
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_mem[cmd_reg.col] <= rd_new_reg;
            newer_mem[cmd_reg.col] <= cmd_reg.pixel;
        end
        if (rd_en) begin
            rd_old_reg <= older_mem[rd_addr];
            rd_new_reg <= newer_mem[rd_addr];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_head;
        end
        if (state_reg == S_SUM) begin
            sum_reg <= sum_now;
            lum_reg <= win_reg[4];
        end
        if (load_out) begin
            m_tdata_reg <= {alpha, lum_reg};
            m_tlast_reg <= last_reg;
            m_tuser_reg <= end_reg;
        end
        ret_reg  <= ret_next;
        last_reg <= last_next;
        end_reg  <= end_next;
        x_reg    <= x_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            win_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            win_reg   <= win_next;
            if (out_free) begin
                m_tvalid_reg <= load_out;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/glyph_outline_alpha_3x3.sv
// ----------------------------------------------------------------------------
// glyph_outline_alpha_3x3: outline alpha filter for 8-bit glyph coverage
// Weighted 3x3 neighborhood sum per pixel, alpha = gain*sum/65536 + pixel.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one coverage pixel per beat in raster order. m_ channel
//   gives one result per beat: luminance and alpha in m_tdata, m_tlast on the
//   last result caused by an input beat, m_tuser on the final result of the
//   image. Results trail the input by one line plus one pixel; the last pixel
//   of the image flushes the remaining results, at most 64 per input beat.
//   Config (cfg_we/cfg_addr/cfg_wdata) sets width, height and gain; write it
//   only while the block is idle.
// Timing:
//   a pixel beat is classified by the front and queued (two entries). The
//   back sequencer handles one command at a time and pops the next only after
//   it has loaded every result of the current one into the output register.
//   A flush replays both stored lines; at width 63 the closing result falls
//   past the cap. Each result is summed into a register before it is loaded
//   into the output register.
// Reset and stall:
//   synchronous active-low reset empties the queue, clears window and
//   position, and restores width 16, height 16, gain 128. When the receiver
//   stalls, the output register holds, the back waits, the queue fills and
//   s_tready falls.
// ----------------------------------------------------------------------------
module glyph_outline_alpha_3x3 (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [goa3_pkg::PIX_W-1:0]          s_tdata,    // [7:0] pixel_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*goa3_pkg::PIX_W-1:0]        m_tdata,    // [7:0] luminance, [15:8] alpha
    output logic                                m_tlast,    // run_last
    output logic                                m_tuser,    // image_end
    input  logic                                cfg_we,
    input  logic [goa3_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [goa3_pkg::ROW_W-1:0]          cfg_wdata
);

    logic [goa3_pkg::COL_W-1:0]  image_width_reg;
    logic [goa3_pkg::ROW_W-1:0]  image_height_reg;
    logic [goa3_pkg::GAIN_W-1:0] outline_gain_reg;

    logic           q_push, q_pop, q_full, q_empty;
    goa3_pkg::cmd_t q_cmd, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= goa3_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= goa3_pkg::RST_IMAGE_HEIGHT;
            outline_gain_reg <= goa3_pkg::RST_OUTLINE_GAIN;
        end else if (cfg_we) begin
            case (cfg_addr)
                goa3_pkg::CFG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata[goa3_pkg::COL_W-1:0];
                end
                goa3_pkg::CFG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_wdata;
                end
                goa3_pkg::CFG_OUTLINE_GAIN: begin
                    outline_gain_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    goa3_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    goa3_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    goa3_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (image_width_reg),
        .outline_gain (outline_gain_reg),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

FILE: rtl/core/goa3_checker.sv
// ----------------------------------------------------------------------------
// goa3_checker: port-level checks for the outline alpha filter
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module goa3_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [2*goa3_pkg::PIX_W-1:0]       m_tdata,
    input logic                               m_tlast,
    input logic                               m_tuser
);

    // output register is empty right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // image end is always the closing result of its input beat
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image end without last");

    // alpha adds a non-negative term to the pixel and saturates
    a_alpha_ge_lum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:8] >= m_tdata[7:0])
        else $error("alpha below luminance");

endmodule

bind glyph_outline_alpha_3x3 goa3_checker u_goa3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: test/glyph_outline_alpha_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_outline_alpha_3x3_tb: self-checking bench for the outline alpha filter
// Streams coverage rasters through the filter under a range of image sizes and
// gains, predicts every result beat from its own copy of the line stores and
// 3x3 window, and compares each output beat field by field in arrival order.
// Covers size clamping, mid-image restarts after a size change, full flushes,
// and source gaps and sink stalls in several mixes.
// ----------------------------------------------------------------------------
module glyph_outline_alpha_3x3_tb;
    import goa3_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int TARGET_PIXELS = 460;
    localparam int SETTLE_CYCLES = 32;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [PIX_W-1:0] luminance;
        logic [PIX_W-1:0] alpha;
        logic             run_last;
        logic             image_end;
    } outline_beat_t;

    class outline_scoreboard;
        logic [COL_W-1:0]  cfg_width;
        logic [ROW_W-1:0]  cfg_height;
        logic [GAIN_W-1:0] cfg_gain;
        logic [PIX_W-1:0]  older_line [LINE_DEPTH];
        logic [PIX_W-1:0]  newer_line [LINE_DEPTH];
        logic [PIX_W-1:0]  win [9];  // row 0 oldest line, col 2 newest column
        logic [COL_W-1:0]  col_pos;
        logic [ROW_W-1:0]  row_pos;
        outline_beat_t     expected_beats [$];
        int                errors;
        int                matched;
        int                images;
        int                restarts;

        function new();
            cfg_width  = RST_IMAGE_WIDTH;
            cfg_height = RST_IMAGE_HEIGHT;
            cfg_gain   = RST_OUTLINE_GAIN;
            foreach (older_line[i]) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            clear_window();
            col_pos  = '0;
            row_pos  = '0;
            errors   = 0;
            matched  = 0;
            images   = 0;
            restarts = 0;
        endfunction

        function int width_now();
            int w;
            w = cfg_width;
            if (w < MIN_SIZE) w = MIN_SIZE;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        function int height_now();
            int h;
            h = cfg_height;
            if (h < MIN_SIZE) h = MIN_SIZE;
            return h;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [ROW_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  cfg_width  = val[COL_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_height = val;
                CFG_OUTLINE_GAIN: cfg_gain   = val;
                default: ;
            endcase
        endfunction

        function void clear_window();
            foreach (win[i]) win[i] = '0;
        endfunction

        function void shift_in(logic [PIX_W-1:0] top_px, logic [PIX_W-1:0] mid_px,
                               logic [PIX_W-1:0] bot_px);
            logic [PIX_W-1:0] fresh [3];
            fresh[0] = top_px;
            fresh[1] = mid_px;
            fresh[2] = bot_px;
            for (int i = 0; i < 3; i++) begin
                win[i*3]   = win[i*3+1];
                win[i*3+1] = win[i*3+2];
                win[i*3+2] = fresh[i];
            end
        endfunction

        function outline_beat_t center_beat(logic end_flag);
            int unsigned side, diag, nsum, a;
            outline_beat_t b;
            side = int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]);
            diag = int'(win[0]) + int'(win[2]) + int'(win[6]) + int'(win[8]);
            nsum = (side << SIDE_SHIFT) + diag * DIAG_WEIGHT;
            a = ((int'(cfg_gain) * nsum) >> GAIN_SHIFT) + int'(win[4]);
            if (a > 255) a = 255;
            b.luminance = win[4];
            b.alpha     = 8'(a);
            b.run_last  = 1'b0;
            b.image_end = end_flag;
            return b;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            outline_beat_t step_beats [$];
            outline_beat_t b;
            logic [PIX_W-1:0] top_px, mid_px;
            int w, h;
            w = width_now();
            h = height_now();
            // a size change left the position outside the image: start over
            if (col_pos >= w || row_pos >= h) begin
                col_pos = '0;
                row_pos = '0;
                clear_window();
                restarts++;
            end
            if (col_pos == 0) begin
                if (row_pos >= 2) begin
                    shift_in('0, '0, '0);
                    step_beats.push_back(center_beat(1'b0));
                end
                clear_window();
            end
            top_px = (row_pos >= 2) ? older_line[col_pos] : '0;
            mid_px = (row_pos >= 1) ? newer_line[col_pos] : '0;
            older_line[col_pos] = newer_line[col_pos];
            newer_line[col_pos] = pix;
            shift_in(top_px, mid_px, pix);
            if (row_pos >= 1 && col_pos >= 1) step_beats.push_back(center_beat(1'b0));

            if (row_pos == h - 1 && col_pos == w - 1) begin
                // final pixel: rest of the second-last line, then the last line
                shift_in('0, '0, '0);
                step_beats.push_back(center_beat(1'b0));
                clear_window();
                for (int x = 0; x < w; x++) begin
                    shift_in(older_line[x], newer_line[x], '0);
                    if (x >= 1) step_beats.push_back(center_beat(1'b0));
                end
                shift_in('0, '0, '0);
                step_beats.push_back(center_beat(1'b1));
                clear_window();
                col_pos = '0;
                row_pos = '0;
                images++;
            end else if (col_pos + 1 >= w) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end else begin
                col_pos = col_pos + 1'b1;
            end

            // one input beat causes at most MAX_RESULTS results, later ones are lost
            while (step_beats.size() > MAX_RESULTS) void'(step_beats.pop_back());

            foreach (step_beats[i]) begin
                b = step_beats[i];
                b.run_last = (i == step_beats.size() - 1);
                expected_beats.push_back(b);
            end
        endfunction

        function void check_beat(outline_beat_t got);
            outline_beat_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat lum=%0d alpha=%0d last=%0b end=%0b",
                         $time, got.luminance, got.alpha, got.run_last, got.image_end);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got !== want) begin
                $display("%0t: beat %0d expected lum=%0d alpha=%0d last=%0b end=%0b",
                         $time, matched + errors, want.luminance, want.alpha,
                         want.run_last, want.image_end);
                $display("%0t:          actual lum=%0d alpha=%0d last=%0b end=%0b",
                         $time, got.luminance, got.alpha, got.run_last, got.image_end);
                errors++;
            end else begin
                matched++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [PIX_W-1:0]        s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [2*PIX_W-1:0]      m_tdata;   // [7:0] luminance, [15:8] alpha
    logic                    m_tlast;   // run_last
    logic                    m_tuser;   // image_end
    logic                    cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [ROW_W-1:0]        cfg_wdata = '0;

    outline_scoreboard sb;
    int gap_pct       = 0;
    int stall_pct     = 0;
    int pixels_sent   = 0;
    int config_writes = 0;
    int phases        = 0;
    int cycle_count   = 0;

    glyph_outline_alpha_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_beat(outline_beat_t'({m_tdata[PIX_W-1:0], m_tdata[2*PIX_W-1:PIX_W],
                                           m_tlast, m_tuser}));
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [PIX_W-1:0] coverage_sample();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(pix);
        pixels_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx, input logic [ROW_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        config_writes++;
    endtask

    task automatic feed_pixels(input int n);
        for (int k = 0; k < n; k++) begin
            // now and then hold the source until the output is empty
            if ($urandom_range(199) == 0) drain_results();
            send_pixel(coverage_sample());
        end
    endtask

    task automatic run_phase(input int idx);
        int w_val, h_val, g_val, w_eff, h_eff, n_img, part_max;
        bit stop_mid;
        drain_results();
        settle();

        g_val = $urandom_range(255);
        if ($urandom_range(5) == 0) g_val = $urandom_range(1) ? 255 : 0;
        w_val = $urandom_range(3, 10);
        h_val = $urandom_range(3, 8);
        n_img = $urandom_range(1, 3);
        if ($urandom_range(7) == 0) w_val = $urandom_range(0, 2);
        if ($urandom_range(7) == 0) h_val = $urandom_range(0, 2);
        if (idx == 1) begin
            w_val = MAX_WIDTH;
            h_val = MIN_SIZE;
            n_img = 1;
        end
        if (idx == 3) begin
            w_val = MIN_SIZE;
            h_val = 255;
            n_img = 0;
        end
        // stopped mid-image: shrink a dimension so the next pixel restarts
        if (sb.col_pos != 0 || sb.row_pos != 0) begin
            if (sb.col_pos >= MIN_SIZE && $urandom_range(1)) w_val = $urandom_range(0, sb.col_pos);
            else h_val = $urandom_range(0, sb.row_pos);
        end

        write_cfg(CFG_IMAGE_WIDTH, {2'($urandom_range(3)), 6'(w_val)});
        write_cfg(CFG_IMAGE_HEIGHT, ROW_W'(h_val));
        write_cfg(CFG_OUTLINE_GAIN, ROW_W'(g_val));
        cfg_we <= 1'b0;

        case (idx % 4)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 58; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 58; end
            default: begin gap_pct = 32; stall_pct = 32; end
        endcase

        w_eff = sb.width_now();
        h_eff = sb.height_now();
        repeat (n_img) feed_pixels(w_eff * h_eff);

        // leave an image unfinished past its third line
        stop_mid = (idx == 3) || (idx >= 4 && $urandom_range(3) == 0);
        if (stop_mid && h_eff >= 4) begin
            part_max = w_eff * (h_eff - 3);
            if (part_max > 3 * w_eff) part_max = 3 * w_eff;
            feed_pixels(3 * w_eff + $urandom_range(0, part_max - 1));
        end
        phases++;
    endtask

    initial begin
        int idx;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest image with clamped size registers, full gain, checkerboard
        write_cfg(CFG_IMAGE_WIDTH, 8'hC0);
        write_cfg(CFG_IMAGE_HEIGHT, 8'd1);
        write_cfg(CFG_OUTLINE_GAIN, 8'hFF);
        cfg_we <= 1'b0;
        for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'h00 : 8'hFF);
        drain_results();
        settle();

        // zero gain, image left unfinished so the first phase forces a restart
        write_cfg(CFG_IMAGE_WIDTH, 8'd3);
        write_cfg(CFG_IMAGE_HEIGHT, 8'd5);
        write_cfg(CFG_OUTLINE_GAIN, 8'd0);
        cfg_we <= 1'b0;
        for (int k = 0; k < 10; k++) send_pixel(coverage_sample());

        idx = 0;
        while (pixels_sent < TARGET_PIXELS || idx < 4) begin
            run_phase(idx);
            idx++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("sent %0d pixels over %0d phases, %0d images completed, %0d restarts",
                 pixels_sent, phases, sb.images, sb.restarts);
        $display("%0d result beats matched, %0d register writes, %0d cycles",
                 sb.matched, config_writes, cycle_count);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/goa3_pkg.sv
rtl/core/goa3_front.sv
rtl/core/goa3_fifo.sv
rtl/core/goa3_back.sv
rtl/core/glyph_outline_alpha_3x3.sv
rtl/core/goa3_checker.sv
test/glyph_outline_alpha_3x3_tb.sv
